// File: rtl/core/swtq_pkg.sv
`default_nettype none
// ============================================================================
// swtq_pkg: shared types and constants of the sorted wakeup timer queue
// Entry and cell-control types, result codes and the controller states.
// ============================================================================
package swtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TIME_W = 64;
  localparam int ID_W   = 8;
  localparam int DUR_W  = 32;
  localparam int KIND_W = 2;
  localparam int NOW_W  = 63;

  // request codes
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result codes
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] key;
    logic [ID_W-1:0]   new_id;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAKE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/swtq_if.sv
`default_nettype none
// ============================================================================
// swtq_if: request and result channels of the sorted wakeup timer queue
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ============================================================================
interface swtq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [swtq_pkg::ID_W-1:0]  thread_id;
  logic [swtq_pkg::DUR_W-1:0] sleep_ticks;

  modport source (output valid, req_type, thread_id, sleep_ticks, input ready);
  modport sink   (input valid, req_type, thread_id, sleep_ticks, output ready);
endinterface

interface swtq_res_if;
  logic                        valid;
  logic                        ready;
  logic [swtq_pkg::KIND_W-1:0] result_kind;
  logic [swtq_pkg::ID_W-1:0]   woken_id;
  logic [swtq_pkg::NOW_W-1:0]  tick_now;
  logic                        last_result;

  modport source (output valid, result_kind, woken_id, tick_now, last_result,
                  input ready);
  modport sink   (input valid, result_kind, woken_id, tick_now, last_result,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/swtq_cell.sv
`default_nettype none
// ============================================================================
// swtq_cell: one slot of the sorted sleeper chain
// Holds one entry, compares it with the broadcast key and shifts with its
// neighbors on insert (toward the tail) and pop (toward the head).
// ============================================================================
module swtq_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire swtq_pkg::cell_ctrl_t ctrl,
  input  wire swtq_pkg::entry_t     prev_ent,
  input  wire                       prev_le,
  input  wire swtq_pkg::entry_t     next_ent,
  output swtq_pkg::entry_t          ent,
  output logic                      le
);

  logic                        valid;
  logic [swtq_pkg::TIME_W-1:0] wake;
  logic [swtq_pkg::ID_W-1:0]   id;

  assign ent = '{valid: valid, wake: wake, id: id};
  // entry sorts at or before the key
  assign le  = valid && (wake <= ctrl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        swtq_pkg::CELL_INSERT: begin
          if (!le) begin
            valid <= prev_le ? 1'b1 : prev_ent.valid;
          end
        end
        swtq_pkg::CELL_POP: valid <= next_ent.valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      swtq_pkg::CELL_INSERT: begin
        if (!le) begin
          if (prev_le) begin
            wake <= ctrl.key;
            id   <= ctrl.new_id;
          end else begin
            wake <= prev_ent.wake;
            id   <= prev_ent.id;
          end
        end
      end
      swtq_pkg::CELL_POP: begin
        wake <= next_ent.wake;
        id   <= next_ent.id;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/sorted_wakeup_timer_queue.sv
`default_nettype none
// ============================================================================
// sorted_wakeup_timer_queue: tick counter with a wake-time sorted sleeper queue
// Chain of QUEUE_DEPTH cells kept sorted by wake time, plus a small controller.
// ============================================================================
// A sleep request broadcasts its saturated wake time (count + duration)
// to every cell; each cell compares it with its own entry, and the chain
// opens a gap behind all entries due at or before it, so equal wake times
// keep arrival order. The request is answered by one beat, queued or
// rejected when the last cell is occupied. A tick first bumps the 64-bit
// count and enters the wake state, also when none is due, which pops one
// woken sleeper per beat: the head cell is compared against the count and
// the chain shifts toward the head by one entry per wake beat; the cell behind
// the head tells whether the beat is the last one. Ticks that wake nobody give no beat.
// The result register decouples the sides: a new request is taken while a
// finished beat still waits, as long as that beat leaves in the same cycle.
// A full wake burst stalls with the result channel. No clearing pass is needed
// after reset; only the cells' valid flags are reset.
// ============================================================================
module sorted_wakeup_timer_queue #(
  parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  swtq_req_if.sink   req,
  swtq_res_if.source res
);

  localparam int TW = swtq_pkg::TIME_W;

  swtq_pkg::state_t     state, state_next;
  logic [TW-1:0]        count, count_next;
  swtq_pkg::cell_ctrl_t ctrl;
  swtq_pkg::entry_t     ent [QUEUE_DEPTH];
  logic                 le  [QUEUE_DEPTH];

  // result register
  logic                          out_valid;
  logic [swtq_pkg::KIND_W-1:0]   out_kind;
  logic [swtq_pkg::ID_W-1:0]     out_id;
  logic [swtq_pkg::NOW_W-1:0]    out_now;
  logic                          out_last;

  logic                          out_free;
  logic                          out_load;
  logic [swtq_pkg::KIND_W-1:0]   load_kind;
  logic [swtq_pkg::ID_W-1:0]     load_id;
  logic                          load_last;
  logic                          full;
  logic [TW:0]                   wake_sum;
  logic [TW-1:0]                 new_wake;

  assign out_free = !out_valid || res.ready;
  assign full     = ent[QUEUE_DEPTH-1].valid;

  // saturate the wake time at the top of the 64-bit range
  assign wake_sum = {1'b0, count} + (TW+1)'(req.sleep_ticks);
  assign new_wake = wake_sum[TW] ? '1 : wake_sum[TW-1:0];

  // ---------------------------------------------------------------------------
  // sleeper chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    swtq_pkg::entry_t prev_ent, next_ent;
    logic             prev_le;

    if (i == 0) begin : g_head
      // head takes the new entry unless its own entry sorts first
      assign prev_ent = '0;
      assign prev_le  = 1'b1;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_le  = le[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    swtq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .prev_ent (prev_ent),
      .prev_le  (prev_le),
      .next_ent (next_ent),
      .ent      (ent[i]),
      .le       (le[i])
    );
  end

  // ---------------------------------------------------------------------------
  // controller
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    req.ready   = 1'b0;
    out_load    = 1'b0;
    load_kind   = swtq_pkg::KIND_QUEUED;
    load_id     = req.thread_id;
    load_last   = 1'b1;
    ctrl.op     = swtq_pkg::CELL_HOLD;
    ctrl.key    = count;
    ctrl.new_id = req.thread_id;

    unique case (state)
      swtq_pkg::ST_IDLE: begin
        req.ready = out_free;
        ctrl.key  = new_wake;
        if (req.valid && out_free) begin
          if (req.req_type == swtq_pkg::REQ_TICK) begin
            // advance the count; the wake scan runs against the new value
            count_next = count + TW'(1);
            state_next = swtq_pkg::ST_WAKE;
          end else begin
            out_load  = 1'b1;
            load_kind = full ? swtq_pkg::KIND_REJECTED : swtq_pkg::KIND_QUEUED;
            ctrl.op   = full ? swtq_pkg::CELL_HOLD : swtq_pkg::CELL_INSERT;
          end
        end
      end
      swtq_pkg::ST_WAKE: begin
        if (le[0]) begin
          if (out_free) begin
            out_load  = 1'b1;
            load_kind = swtq_pkg::KIND_WOKEN;
            load_id   = ent[0].id;
            load_last = !le[1];
            ctrl.op   = swtq_pkg::CELL_POP;
            if (!le[1]) begin
              state_next = swtq_pkg::ST_IDLE;
            end
          end
        end else begin
          // nothing due on this tick: drop back without a beat
          state_next = swtq_pkg::ST_IDLE;
        end
      end
      default: state_next = swtq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= load_kind;
      out_id   <= load_id;
      out_now  <= count[swtq_pkg::NOW_W-1:0];
      out_last <= load_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.woken_id    = out_id;
  assign res.tick_now    = out_now;
  assign res.last_result = out_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_req_in_wake: assert property (@(posedge clk) disable iff (rst)
    state == swtq_pkg::ST_WAKE |-> !req.ready)
    else $error("request taken during a wake burst");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    ent[0].valid && ent[1].valid |-> ent[0].wake <= ent[1].wake)
    else $error("sleeper chain out of order at the head");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    ent[1].valid |-> ent[0].valid)
    else $error("hole at the head of the sleeper chain");

  a_wake_pop: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == swtq_pkg::CELL_POP |-> state == swtq_pkg::ST_WAKE && le[0])
    else $error("pop without a due head entry");

endmodule
`default_nettype wire
